// File: rtl/pcl_pkg.sv
// Package for the piecewise cubic lookup: payload types, codes and defaults.
package pcl_pkg;

    // Default parameter values.
    localparam int DEF_MAX_POINTS = 16;
    localparam int DEF_FRAC_BITS  = 12;

    // Fixed field widths.
    localparam int DIST_W  = 16;
    localparam int COEF_W  = 32;
    localparam int ACC_W   = 48;
    localparam int DX_W    = DIST_W + 1;
    localparam int PTS_W   = 5;
    localparam int SEG_W   = 4;
    localparam int ENTRY_W = 4;

    // Item kinds.
    localparam logic [1:0] KIND_EVAL      = 2'd0;
    localparam logic [1:0] KIND_LOAD_BP   = 2'd1;
    localparam logic [1:0] KIND_LOAD_COEF = 2'd2;

    // Table selects; the unused code falls back to the small pitch table.
    localparam logic [1:0] TBL_SMALL  = 2'd0;
    localparam logic [1:0] TBL_MID    = 2'd1;
    localparam logic [1:0] TBL_LARGE  = 2'd2;
    localparam logic [1:0] TBL_UNUSED = 2'd3;

    // Coefficient selects in Horner order.
    localparam logic [1:0] COEF_CUBIC  = 2'd0;
    localparam logic [1:0] COEF_SQUARE = 2'd1;
    localparam logic [1:0] COEF_LINEAR = 2'd2;
    localparam logic [1:0] COEF_CONST  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_IN_RANGE   = 2'd0;
    localparam logic [1:0] ST_BELOW      = 2'd1;
    localparam logic [1:0] ST_ABOVE      = 2'd2;
    localparam logic [1:0] ST_NOT_LOADED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_SMALL_POINTS = 2'd0;
    localparam logic [1:0] REG_MID_POINTS   = 2'd1;
    localparam logic [1:0] REG_LARGE_POINTS = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]               kind;
        logic [1:0]               table_select;
        logic [ENTRY_W-1:0]       entry_index;
        logic [1:0]               coeff_select;
        logic signed [COEF_W-1:0] coeff_value;
        logic [DIST_W-1:0]        distance;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic signed [COEF_W-1:0] speed;
        logic [SEG_W-1:0]         segment;
        logic [1:0]               status;
    } out_t;

    // Write command into the table store.
    typedef struct packed {
        logic               bp_we;
        logic               cf_we;
        logic [1:0]         table_sel;
        logic [ENTRY_W-1:0] entry;
        logic [1:0]         csel;
        logic [DIST_W-1:0]  bp_data;
        logic [COEF_W-1:0]  cf_data;
    } wr_cmd_t;

    // Control of the shared multiply-add unit.
    typedef struct packed {
        logic load;
        logic mul;
        logic add;
    } mac_ctl_t;

endpackage

// File: rtl/piecewise_cubic_lookup.sv
// Top level of the piecewise cubic lookup: sequencer, point registers and ports.
//
//  Channel   Ports                          Carries
//  input     s_valid, s_ready, s_data       in_t: evaluate or load item
//  result    m_valid, m_ready, m_data       out_t: speed, segment, status
//  config    cfg_we, cfg_index, cfg_wdata   point counts, index 0 to 2
//
// A load item is written on acceptance and the block stays ready. An evaluate
// item passes through acceptance, two end point checks, one binary-search
// step per breakpoint memory read, a step to form dx, three multiply and
// add-saturate passes through the shared unit, and the output step; the
// block is ready again once the result enters the output register.
// A table with fewer than two points or a distance outside the end points
// finishes early with status not loaded, below or above. Reset clears the
// point counts and the handshake state; the memories are not cleared. A
// stalled result holds in the output register while the next item is taken.
module piecewise_cubic_lookup #(
    parameter int MAX_POINTS = pcl_pkg::DEF_MAX_POINTS,
    parameter int FRAC_BITS  = pcl_pkg::DEF_FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pcl_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pcl_pkg::out_t               m_data,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [pcl_pkg::PTS_W-1:0]   cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = ($clog2(MAX_POINTS + 1) > pcl_pkg::PTS_W) ?
                           $clog2(MAX_POINTS + 1) : pcl_pkg::PTS_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CHK_FIRST, S_CHK_LAST, S_SEARCH, S_DX, S_MUL, S_ADD, S_DONE
    } state_t;

    state_t state_reg;

    logic [pcl_pkg::PTS_W-1:0] pts_reg [3];

    logic [1:0]                  t_reg;
    logic [pcl_pkg::DIST_W-1:0]  dist_reg;
    logic [IDX_W-1:0]            last_reg;
    logic [IDX_W-1:0]            left_reg;
    logic [IDX_W-1:0]            right_reg;
    logic [IDX_W-1:0]            mid_reg;
    logic [1:0]                  step_reg;
    logic [1:0]                  pend_status_reg;
    logic                        pend_ok_reg;
    logic                        m_valid_reg;
    pcl_pkg::out_t               m_data_reg;

    logic                        accept;
    logic [1:0]                  in_table;
    logic [CNT_W-1:0]            in_points;
    logic                        load_ok;
    logic [IDX_W-1:0]            new_left;
    logic [IDX_W-1:0]            new_right;

    pcl_pkg::wr_cmd_t            wr;
    pcl_pkg::mac_ctl_t           mac_ctl;
    logic [1:0]                  rd_table;
    logic [IDX_W-1:0]            bp_rd_idx;
    logic [IDX_W-1:0]            cf_rd_idx;
    logic [pcl_pkg::DIST_W-1:0]  bp_rdata;
    logic [pcl_pkg::COEF_W-1:0]  cf_rdata;
    logic signed [pcl_pkg::DX_W-1:0]   dx;
    logic signed [pcl_pkg::COEF_W-1:0] mac_result;

    // Midpoint of the bounds rounded down, plus one, used by the search.
    function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi);
        logic [IDX_W:0] s;
        s = ({1'b0, lo} + {1'b0, hi}) >> 1;
        return IDX_W'(s + (IDX_W+1)'(1));
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Table decode and point count, clamped to the table depth.
    always_comb begin
        in_table = (s_data.table_select == pcl_pkg::TBL_UNUSED) ?
                   pcl_pkg::TBL_SMALL : s_data.table_select;
        case (in_table)
            pcl_pkg::TBL_MID:   in_points = CNT_W'(pts_reg[1]);
            pcl_pkg::TBL_LARGE: in_points = CNT_W'(pts_reg[2]);
            default:            in_points = CNT_W'(pts_reg[0]);
        endcase
        if (in_points > CNT_W'(MAX_POINTS)) begin
            in_points = CNT_W'(MAX_POINTS);
        end
        load_ok = CNT_W'(s_data.entry_index) < CNT_W'(MAX_POINTS);
    end

    // Memory write command for load transactions.
    always_comb begin
        wr.bp_we     = accept && (s_data.kind == pcl_pkg::KIND_LOAD_BP) && load_ok;
        wr.cf_we     = accept && (s_data.kind == pcl_pkg::KIND_LOAD_COEF) && load_ok;
        wr.table_sel = in_table;
        wr.entry     = s_data.entry_index;
        wr.csel      = s_data.coeff_select;
        wr.bp_data   = s_data.distance;
        wr.cf_data   = s_data.coeff_value;
    end

    // Next search bounds from the breakpoint just read.
    always_comb begin
        if (dist_reg <= bp_rdata) begin
            new_left  = left_reg;
            new_right = mid_reg - IDX_W'(1);
        end else begin
            new_left  = mid_reg;
            new_right = right_reg;
        end
    end

    // Read addresses; the store registers the read data.
    always_comb begin
        rd_table  = (state_reg == S_IDLE) ? in_table : t_reg;
        cf_rd_idx = (state_reg == S_SEARCH) ? new_left : left_reg;
        case (state_reg)
            S_IDLE:      bp_rd_idx = '0;
            S_CHK_FIRST: bp_rd_idx = last_reg;
            S_CHK_LAST:  bp_rd_idx = mid_of(left_reg, right_reg);
            S_SEARCH:    bp_rd_idx = (new_left < new_right) ?
                                     mid_of(new_left, new_right) : new_left;
            default:     bp_rd_idx = left_reg;
        endcase
    end

    // Shared unit control.
    always_comb begin
        mac_ctl.load = (state_reg == S_DX);
        mac_ctl.mul  = (state_reg == S_MUL);
        mac_ctl.add  = (state_reg == S_ADD);
        dx = $signed({1'b0, dist_reg}) - $signed({1'b0, bp_rdata});
    end

    // Point count registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pts_reg[0] <= '0;
            pts_reg[1] <= '0;
            pts_reg[2] <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                pcl_pkg::REG_SMALL_POINTS: pts_reg[0] <= cfg_wdata;
                pcl_pkg::REG_MID_POINTS:   pts_reg[1] <= cfg_wdata;
                pcl_pkg::REG_LARGE_POINTS: pts_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer with the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // A taken result clears the valid flag unless a new one replaces it now.
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    t_reg     <= in_table;
                    dist_reg  <= s_data.distance;
                    last_reg  <= IDX_W'(in_points - CNT_W'(1));
                    left_reg  <= '0;
                    right_reg <= IDX_W'(in_points - CNT_W'(1));
                    step_reg  <= pcl_pkg::COEF_CUBIC;
                    if (accept && s_data.kind == pcl_pkg::KIND_EVAL) begin
                        if (in_points < CNT_W'(2)) begin
                            pend_status_reg <= pcl_pkg::ST_NOT_LOADED;
                            pend_ok_reg     <= 1'b0;
                            state_reg       <= S_DONE;
                        end else begin
                            state_reg <= S_CHK_FIRST;
                        end
                    end
                end
                S_CHK_FIRST: begin
                    if (dist_reg < bp_rdata) begin
                        pend_status_reg <= pcl_pkg::ST_BELOW;
                        pend_ok_reg     <= 1'b0;
                        state_reg       <= S_DONE;
                    end else begin
                        state_reg <= S_CHK_LAST;
                    end
                end
                S_CHK_LAST: begin
                    mid_reg <= mid_of(left_reg, right_reg);
                    if (dist_reg > bp_rdata) begin
                        pend_status_reg <= pcl_pkg::ST_ABOVE;
                        pend_ok_reg     <= 1'b0;
                        state_reg       <= S_DONE;
                    end else begin
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    left_reg  <= new_left;
                    right_reg <= new_right;
                    mid_reg   <= mid_of(new_left, new_right);
                    if (!(new_left < new_right)) begin
                        state_reg <= S_DX;
                    end
                end
                S_DX: begin
                    step_reg  <= pcl_pkg::COEF_SQUARE;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    if (step_reg == pcl_pkg::COEF_CONST) begin
                        pend_status_reg <= pcl_pkg::ST_IN_RANGE;
                        pend_ok_reg     <= 1'b1;
                        state_reg       <= S_DONE;
                    end else begin
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_data_reg.status  <= pend_status_reg;
                        m_data_reg.speed   <= pend_ok_reg ? mac_result : '0;
                        m_data_reg.segment <= pend_ok_reg ?
                                              pcl_pkg::SEG_W'(left_reg) : '0;
                        state_reg          <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    pcl_table_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .aclk      (aclk),
        .wr        (wr),
        .rd_table  (rd_table),
        .bp_rd_idx (bp_rd_idx),
        .cf_rd_idx (cf_rd_idx),
        .cf_rd_k   (step_reg),
        .bp_rdata  (bp_rdata),
        .cf_rdata  (cf_rdata)
    );

    pcl_mac_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk   (aclk),
        .ctl    (mac_ctl),
        .coef   ($signed(cf_rdata)),
        .dx_in  (dx),
        .result (mac_result)
    );

endmodule

// File: rtl/pcl_table_store.sv
// Breakpoint and coefficient memories with one write and one registered read each.
module pcl_table_store #(
    parameter int MAX_POINTS = pcl_pkg::DEF_MAX_POINTS
) (
    input  logic                            aclk,
    input  pcl_pkg::wr_cmd_t                wr,
    input  logic [1:0]                      rd_table,
    input  logic [$clog2(MAX_POINTS)-1:0]   bp_rd_idx,
    input  logic [$clog2(MAX_POINTS)-1:0]   cf_rd_idx,
    input  logic [1:0]                      cf_rd_k,
    output logic [pcl_pkg::DIST_W-1:0]      bp_rdata,
    output logic [pcl_pkg::COEF_W-1:0]      cf_rdata
);

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int BP_DEPTH = 3 * MAX_POINTS;
    localparam int BP_AW    = $clog2(BP_DEPTH);
    localparam int CF_DEPTH = 4 * BP_DEPTH;
    localparam int CF_AW    = BP_AW + 2;

    logic [pcl_pkg::DIST_W-1:0] bp_mem [BP_DEPTH];
    logic [pcl_pkg::COEF_W-1:0] cf_mem [CF_DEPTH];

    logic [BP_AW-1:0] wr_row;
    logic [BP_AW-1:0] bp_rd_row;
    logic [BP_AW-1:0] cf_rd_row;

    // Row address of one table entry: table times depth plus index.
    function automatic logic [BP_AW-1:0] row_of(input logic [1:0] tsel,
                                                input logic [IDX_W-1:0] idx);
        logic [BP_AW-1:0] base;
        base = BP_AW'(tsel) * BP_AW'(MAX_POINTS);
        return base + BP_AW'(idx);
    endfunction

    assign wr_row    = row_of(wr.table_sel, IDX_W'(wr.entry));
    assign bp_rd_row = row_of(rd_table, bp_rd_idx);
    assign cf_rd_row = row_of(rd_table, cf_rd_idx);

    // Breakpoint memory.
    always_ff @(posedge aclk) begin
        if (wr.bp_we) begin
            bp_mem[wr_row] <= wr.bp_data;
        end
        bp_rdata <= bp_mem[bp_rd_row];
    end

    // Coefficient memory, four words per segment.
    always_ff @(posedge aclk) begin
        if (wr.cf_we) begin
            cf_mem[CF_AW'({wr_row, wr.csel})] <= wr.cf_data;
        end
        cf_rdata <= cf_mem[CF_AW'({cf_rd_row, cf_rd_k})];
    end

endmodule

// File: rtl/pcl_mac_unit.sv
// Shared multiply and add-saturate unit that runs the Horner steps.
module pcl_mac_unit #(
    parameter int FRAC_BITS = pcl_pkg::DEF_FRAC_BITS
) (
    input  logic                               aclk,
    input  pcl_pkg::mac_ctl_t                  ctl,
    input  logic signed [pcl_pkg::COEF_W-1:0]  coef,
    input  logic signed [pcl_pkg::DX_W-1:0]    dx_in,
    output logic signed [pcl_pkg::COEF_W-1:0]  result
);

    localparam int ACC_W  = pcl_pkg::ACC_W;
    localparam int PROD_W = ACC_W + pcl_pkg::DX_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);
    localparam logic signed [ACC_W-1:0] RES_HI = ACC_W'({1'b0, {(pcl_pkg::COEF_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] RES_LO = -RES_HI - ACC_W'(1);

    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [pcl_pkg::DX_W-1:0]    dx_reg;
    logic signed [PROD_W-1:0]           prod_reg;
    logic signed [SUM_W-1:0]            sum;
    logic signed [ACC_W-1:0]            acc_next;

    // Floored product plus coefficient, clamped to the accumulator range.
    always_comb begin
        sum = SUM_W'(prod_reg >>> FRAC_BITS) + SUM_W'(coef);
        if (sum > ACC_HI) begin
            acc_next = ACC_HI[ACC_W-1:0];
        end else if (sum < ACC_LO) begin
            acc_next = ACC_LO[ACC_W-1:0];
        end else begin
            acc_next = sum[ACC_W-1:0];
        end
    end

    // Accumulator, dx and product registers.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            acc_reg <= ACC_W'(coef);
            dx_reg  <= dx_in;
        end else if (ctl.add) begin
            acc_reg <= acc_next;
        end
        if (ctl.mul) begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(dx_reg);
        end
    end

    // Final clamp to the 32-bit speed range.
    always_comb begin
        if (acc_reg > RES_HI) begin
            result = RES_HI[pcl_pkg::COEF_W-1:0];
        end else if (acc_reg < RES_LO) begin
            result = RES_LO[pcl_pkg::COEF_W-1:0];
        end else begin
            result = acc_reg[pcl_pkg::COEF_W-1:0];
        end
    end

endmodule
